>>> sv/rgb_to_hsv_pixel_core_assert.svh
// Assertion macros for the RGB to HSV pixel core.
// Needs clk_i and rst_ni in the module that includes it.
`ifndef RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH

// general clocked property, off during reset
`define RTHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property that must hold whenever a stage holds a valid item
`define RTHP_ASSERT_VLD(label, vld, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (vld) |-> (prop)) \
    else $error(msg);

`endif

>>> sv/rthp_pkg.sv
// Shared types for the RGB to HSV pixel core.
// No dependencies.
package rthp_pkg;

  // control that travels alongside every item down the pipeline
  typedef struct packed {
    logic valid;
    logic gray;   // chroma is zero: hue and saturation forced to zero
  } rthp_ctl_t;

  // channel that holds the maximum, first match in red, green, blue order
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } rthp_sector_e;

endpackage

>>> sv/rthp_front.sv
// Front end: max/min, chroma, divisor and dividend set-up (two stages).
// Depends on rthp_pkg and rgb_to_hsv_pixel_core_assert.svh.
`include "rgb_to_hsv_pixel_core_assert.svh"

module rthp_front #(
  parameter int unsigned CHANNEL_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [CHANNEL_BITS-1:0]   red_i,
  input  logic [CHANNEL_BITS-1:0]   green_i,
  input  logic [CHANNEL_BITS-1:0]   blue_i,
  input  logic                      ready_i,
  output rthp_pkg::rthp_ctl_t       ctl_o,
  output logic [CHANNEL_BITS-1:0]   value_o,
  output logic [CHANNEL_BITS-1:0]   sat_rem_o,
  output logic [CHANNEL_BITS-1:0]   sat_low_o,
  output logic [CHANNEL_BITS+2:0]   hue_rem_o,
  output logic [CHANNEL_BITS+2:0]   hue_div_o
);

  localparam int unsigned N = CHANNEL_BITS;

  // stage 1 registers
  logic                   s1_valid_q;
  logic [N-1:0]           s1_red_q, s1_green_q, s1_blue_q, s1_max_q, s1_min_q;
  rthp_pkg::rthp_sector_e s1_sec_q, s1_sec_d;
  logic [N-1:0]           s1_max_d, s1_min_d, min_rg;

  // stage 2 registers
  rthp_pkg::rthp_ctl_t    ctl_q;
  logic [N-1:0]           value_q, sat_rem_q, sat_low_q;
  logic [N+2:0]           hue_rem_q, hue_div_q;

  logic                   s1_ready, s2_ready;
  logic [N-1:0]           chroma, lead, trail;
  logic [N+2:0]           div6, offs;
  logic [N+3:0]           num, num_red;
  logic [2*N-1:0]         sat_num;

  assign s2_ready = !ctl_q.valid || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // stage 1: find max, min and the leading channel
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      s1_sec_d = rthp_pkg::SEC_RED;
      s1_max_d = red_i;
    end else if (green_i >= blue_i) begin
      s1_sec_d = rthp_pkg::SEC_GREEN;
      s1_max_d = green_i;
    end else begin
      s1_sec_d = rthp_pkg::SEC_BLUE;
      s1_max_d = blue_i;
    end
    min_rg   = (red_i < green_i) ? red_i : green_i;
    s1_min_d = (min_rg < blue_i) ? min_rg : blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_max_q   <= s1_max_d;
      s1_min_q   <= s1_min_d;
      s1_sec_q   <= s1_sec_d;
    end
  end

  // stage 2: chroma, 6C divisor, hue dividend with one turn added
  assign chroma = s1_max_q - s1_min_q;
  assign div6   = ({3'b000, chroma} << 2) + ({3'b000, chroma} << 1);

  always_comb begin
    case (s1_sec_q)
      rthp_pkg::SEC_RED: begin
        lead  = s1_green_q;
        trail = s1_blue_q;
        offs  = '0;
      end
      rthp_pkg::SEC_GREEN: begin
        lead  = s1_blue_q;
        trail = s1_red_q;
        offs  = {3'b000, chroma} << 1;
      end
      rthp_pkg::SEC_BLUE: begin
        lead  = s1_red_q;
        trail = s1_green_q;
        offs  = {3'b000, chroma} << 2;
      end
      default: begin
        lead  = '0;
        trail = '0;
        offs  = '0;
      end
    endcase
  end

  // never negative: diff >= -C and a full turn (6C) is added
  assign num     = {4'b0000, lead} + {1'b0, div6} + {1'b0, offs} - {4'b0000, trail};
  // integer part of num/6C is 0 or 1; strip it, it wraps away
  assign num_red = (num >= {1'b0, div6}) ? (num - {1'b0, div6}) : num;
  // (2^N - 1) * C
  assign sat_num = {chroma, {N{1'b0}}} - {{N{1'b0}}, chroma};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (s2_ready) begin
      ctl_q.valid <= s1_valid_q;
      ctl_q.gray  <= (chroma == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      value_q   <= s1_max_q;
      sat_rem_q <= sat_num[2*N-1:N];
      sat_low_q <= sat_num[N-1:0];
      hue_rem_q <= num_red[N+2:0];
      hue_div_q <= div6;
    end
  end

  assign ctl_o     = ctl_q;
  assign value_o   = value_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_low_o = sat_low_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;

  `RTHP_ASSERT_VLD(a_front_gray_div, ctl_q.valid, ctl_q.gray == (hue_div_q == '0), "gray flag disagrees with divisor")
  `RTHP_ASSERT_VLD(a_front_hue_rem, ctl_q.valid && !ctl_q.gray, hue_rem_q < hue_div_q, "hue remainder not reduced")

endmodule

>>> sv/rthp_div_cell.sv
// One restoring-division cell: one quotient bit for saturation and hue.
// Depends on rthp_pkg and rgb_to_hsv_pixel_core_assert.svh.
`include "rgb_to_hsv_pixel_core_assert.svh"

module rthp_div_cell #(
  parameter int unsigned CHANNEL_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  output logic                      ready_o,
  input  logic                      ready_i,
  input  rthp_pkg::rthp_ctl_t       ctl_i,
  input  logic [CHANNEL_BITS-1:0]   value_i,
  input  logic [CHANNEL_BITS-1:0]   sat_rem_i,
  input  logic [CHANNEL_BITS-1:0]   sat_low_i,
  input  logic [CHANNEL_BITS-1:0]   sat_quo_i,
  input  logic [CHANNEL_BITS+2:0]   hue_rem_i,
  input  logic [CHANNEL_BITS+2:0]   hue_div_i,
  input  logic [CHANNEL_BITS-1:0]   hue_quo_i,
  output rthp_pkg::rthp_ctl_t       ctl_o,
  output logic [CHANNEL_BITS-1:0]   value_o,
  output logic [CHANNEL_BITS-1:0]   sat_rem_o,
  output logic [CHANNEL_BITS-1:0]   sat_low_o,
  output logic [CHANNEL_BITS-1:0]   sat_quo_o,
  output logic [CHANNEL_BITS+2:0]   hue_rem_o,
  output logic [CHANNEL_BITS+2:0]   hue_div_o,
  output logic [CHANNEL_BITS-1:0]   hue_quo_o
);

  localparam int unsigned N = CHANNEL_BITS;

  rthp_pkg::rthp_ctl_t ctl_q;
  logic [N-1:0]        value_q, sat_rem_q, sat_low_q, sat_quo_q, hue_quo_q;
  logic [N+2:0]        hue_rem_q, hue_div_q;

  logic [N:0]          sat_try, sat_sub;
  logic [N+3:0]        hue_try, hue_sub;
  logic                sat_bit, hue_bit;
  logic                ready;

  assign ready   = !ctl_q.valid || ready_i;
  assign ready_o = ready;

  // shift in next dividend bit, trial subtract
  assign sat_try = {sat_rem_i, sat_low_i[N-1]};
  assign sat_sub = sat_try - {1'b0, value_i};
  assign sat_bit = (sat_try >= {1'b0, value_i});

  assign hue_try = {hue_rem_i, 1'b0};
  assign hue_sub = hue_try - {1'b0, hue_div_i};
  assign hue_bit = (hue_try >= {1'b0, hue_div_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid && ready) begin
      value_q   <= value_i;
      sat_rem_q <= sat_bit ? sat_sub[N-1:0] : sat_try[N-1:0];
      sat_low_q <= {sat_low_i[N-2:0], 1'b0};
      sat_quo_q <= {sat_quo_i[N-2:0], sat_bit};
      hue_rem_q <= hue_bit ? hue_sub[N+2:0] : hue_try[N+2:0];
      hue_div_q <= hue_div_i;
      hue_quo_q <= {hue_quo_i[N-2:0], hue_bit};
    end
  end

  assign ctl_o     = ctl_q;
  assign value_o   = value_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_low_o = sat_low_q;
  assign sat_quo_o = sat_quo_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign hue_quo_o = hue_quo_q;

  `RTHP_ASSERT_VLD(a_cell_sat_rem, ctl_q.valid && !ctl_q.gray, sat_rem_q < value_q, "saturation remainder not below value")
  `RTHP_ASSERT_VLD(a_cell_hue_rem, ctl_q.valid && !ctl_q.gray, hue_rem_q < hue_div_q, "hue remainder not below 6C")

endmodule

>>> sv/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel converter, fixed point, one item in and one item out.
// Pipeline: two set-up stages, then one division cell per quotient bit.
// Throughput: one item per cycle while the output is not back-pressured.
// Each stage holds its item under back-pressure and frees as soon as it moves.
// Reset (rst_ni, async, active low) clears all valid flags; data is not reset.
// Depends on rthp_pkg, rthp_front, rthp_div_cell and the assertion header.
`include "rgb_to_hsv_pixel_core_assert.svh"

module rgb_to_hsv_pixel_core #(
  parameter int unsigned CHANNEL_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // red, green, blue from bit 0 up, zero pad to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // hue, saturation, value from bit 0 up, zero pad to whole bytes
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned N       = CHANNEL_BITS;
  localparam int unsigned TDATA_W = ((3*CHANNEL_BITS+7)/8)*8;

  // chain taps: index 0 is the front end output, index N the last cell
  rthp_pkg::rthp_ctl_t ctl   [0:N];
  logic [N-1:0]        value [0:N];
  logic [N-1:0]        s_rem [0:N];
  logic [N-1:0]        s_low [0:N];
  logic [N-1:0]        s_quo [0:N];
  logic [N+2:0]        h_rem [0:N];
  logic [N+2:0]        h_div [0:N];
  logic [N-1:0]        h_quo [0:N];
  logic                rdy   [0:N];   // ready from each tap's consumer

  logic [N-1:0]        out_hue, out_sat, out_value;

  rthp_front #(
    .CHANNEL_BITS(N)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .red_i     (s_axis_tdata[N-1:0]),
    .green_i   (s_axis_tdata[2*N-1:N]),
    .blue_i    (s_axis_tdata[3*N-1:2*N]),
    .ready_i   (rdy[0]),
    .ctl_o     (ctl[0]),
    .value_o   (value[0]),
    .sat_rem_o (s_rem[0]),
    .sat_low_o (s_low[0]),
    .hue_rem_o (h_rem[0]),
    .hue_div_o (h_div[0])
  );

  // quotients start empty and fill one bit per cell
  assign s_quo[0] = '0;
  assign h_quo[0] = '0;

  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    rthp_div_cell #(
      .CHANNEL_BITS(N)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ready_o   (rdy[gi]),
      .ready_i   (rdy[gi+1]),
      .ctl_i     (ctl[gi]),
      .value_i   (value[gi]),
      .sat_rem_i (s_rem[gi]),
      .sat_low_i (s_low[gi]),
      .sat_quo_i (s_quo[gi]),
      .hue_rem_i (h_rem[gi]),
      .hue_div_i (h_div[gi]),
      .hue_quo_i (h_quo[gi]),
      .ctl_o     (ctl[gi+1]),
      .value_o   (value[gi+1]),
      .sat_rem_o (s_rem[gi+1]),
      .sat_low_o (s_low[gi+1]),
      .sat_quo_o (s_quo[gi+1]),
      .hue_rem_o (h_rem[gi+1]),
      .hue_div_o (h_div[gi+1]),
      .hue_quo_o (h_quo[gi+1])
    );
  end

  // last cell is the output register
  assign rdy[N]        = m_axis_tready;
  assign m_axis_tvalid = ctl[N].valid;

  // zero chroma: divisors may be zero, so both quotients are meaningless
  assign out_hue   = ctl[N].gray ? '0 : h_quo[N];
  assign out_sat   = ctl[N].gray ? '0 : s_quo[N];
  assign out_value = value[N];

  assign m_axis_tdata = TDATA_W'({out_value, out_sat, out_hue});

  `RTHP_ASSERT(a_black_pixel, (m_axis_tvalid && out_value == '0) |-> (out_sat == '0 && out_hue == '0), "black pixel with nonzero hue or saturation")

endmodule
